// File: src/sstlv_pkg.sv
// Shared types, codes and lookup functions of the send-stream TLV parser.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package sstlv_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned VERSION_W = 32;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned TDATA_W   = 128;
    localparam int unsigned TUSER_W   = 4;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    // stream header and command/attribute header layout (byte counts)
    localparam logic [CNT_W-1:0] MAGIC_LEN     = 5'd13;
    localparam logic [CNT_W-1:0] VERSION_LAST  = 5'd16;
    localparam logic [CNT_W-1:0] CMD_LEN_END   = 5'd4;
    localparam logic [CNT_W-1:0] CMD_CODE_END  = 5'd6;
    localparam logic [CNT_W-1:0] CMD_HDR_LAST  = 5'd9;
    localparam logic [CNT_W-1:0] ATTR_TYPE_END = 5'd2;
    localparam logic [CNT_W-1:0] ATTR_HDR_LAST = 5'd3;
    localparam logic [31:0]      ATTR_HDR_LEN  = 32'd4;

    localparam logic [31:0] MAX_VERSION_RESET = 32'd3;
    localparam logic        REG_MAX_VERSION   = 1'b0;

    // byte roles
    localparam logic [2:0] ROLE_STREAM  = 3'd0;
    localparam logic [2:0] ROLE_CMD     = 3'd1;
    localparam logic [2:0] ROLE_ATTR    = 3'd2;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
    localparam logic [2:0] ROLE_DISCARD = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_VERSION   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_BAD_LEN   = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;

    // required payload lengths
    localparam logic [15:0] LEN_U64  = 16'd8;
    localparam logic [15:0] LEN_U32  = 16'd4;
    localparam logic [15:0] LEN_TIME = 16'd12;

    // payload offsets of value-carrying attributes: last bytes and time nsec start
    localparam logic [15:0] OFF_U64_LAST  = 16'd7;
    localparam logic [15:0] OFF_U32_LAST  = 16'd3;
    localparam logic [15:0] OFF_TIME_SEC  = 16'd7;
    localparam logic [15:0] OFF_TIME_NSEC = 16'd8;
    localparam logic [15:0] OFF_TIME_LAST = 16'd11;

    typedef enum logic [1:0] {
        AC_FREE,
        AC_U64,
        AC_U32,
        AC_TIME
    } t_attr_class;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_item;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic [15:0] command_code;
        logic [15:0] attribute_type;
        logic [15:0] payload_offset;
        logic [7:0]  byte_echo;
        logic        value_valid;
        logic [63:0] field_value;
        logic [2:0]  status;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] v;
        unique case (idx)
            4'd0:    v = 8'h62; // b
            4'd1:    v = 8'h74; // t
            4'd2:    v = 8'h72; // r
            4'd3:    v = 8'h66; // f
            4'd4:    v = 8'h73; // s
            4'd5:    v = 8'h2d; // -
            4'd6:    v = 8'h73; // s
            4'd7:    v = 8'h74; // t
            4'd8:    v = 8'h72; // r
            4'd9:    v = 8'h65; // e
            4'd10:   v = 8'h61; // a
            4'd11:   v = 8'h6d; // m
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic t_attr_class attr_class(input logic [15:0] t);
        t_attr_class c;
        unique case (t)
            16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8,
            16'd18, 16'd21, 16'd23, 16'd24,
            16'd26, 16'd27, 16'd28, 16'd29:  c = AC_U64;
            16'd25, 16'd30, 16'd31:          c = AC_U32;
            16'd9, 16'd10, 16'd11, 16'd12:   c = AC_TIME;
            default:                         c = AC_FREE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/send_stream_tlv_parser.sv
// Top level of the send-stream TLV parser: input beat register, parse core,
// result register and APB register slave. Depends on sstlv_pkg,
// sstlv_apb_regs and sstlv_parse_core.
//
//   channel   | direction | beat contents
//   s_axis    | in        | tdata[7:0] data_byte, tlast end_of_stream
//   m_axis    | out       | tdata: code, type, offset, echo, value, status; tuser: role, valid
//   apb       | in/out    | max_version at byte address 0
//
// One byte per cycle while the output drains; a result beat passes from the
// input register through the parse step into the result register.
// The parse step is one pass through the core's next-state logic.
// Reset is synchronous and active low and needs no clearing pass.
// A stalled output holds its beat; the input register keeps taking beats
// as long as the result register drains.
`default_nettype none

module send_stream_tlv_parser (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [15:0] command_code, [31:16] attribute_type, [47:32] payload_offset,
    // [55:48] byte_echo, [119:56] field_value, [122:120] status, rest zero
    output logic      [sstlv_pkg::TDATA_W-1:0]     m_axis_tdata,
    // [2:0] byte_role, [3] value_valid
    output logic      [sstlv_pkg::TUSER_W-1:0]     m_axis_tuser,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sstlv_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [sstlv_pkg::PDATA_W-1:0]     pwdata,
    output logic      [sstlv_pkg::PDATA_W-1:0]     prdata,
    output logic                                   pready
);

    logic                            r_in_valid;
    sstlv_pkg::t_item                r_in_item;
    logic                            r_out_valid;
    sstlv_pkg::t_result              r_out;
    sstlv_pkg::t_result              w_res;
    logic                            w_advance;
    logic [sstlv_pkg::VERSION_W-1:0] w_max_version;

    sstlv_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_max_version (w_max_version)
    );

    sstlv_parse_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance),
        .i_item        (r_in_item),
        .i_max_version (w_max_version),
        .o_result      (w_res)
    );

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.data_byte     <= s_axis_tdata;
            r_in_item.end_of_stream <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.status, r_out.field_value, r_out.byte_echo,
                            r_out.payload_offset, r_out.attribute_type, r_out.command_code};
    assign m_axis_tuser  = {r_out.value_valid, r_out.byte_role};

endmodule

`default_nettype wire

// File: src/sstlv_apb_regs.sv
// APB register slave of the send-stream TLV parser: holds max_version.
// Depends on sstlv_pkg.
`default_nettype none

module sstlv_apb_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sstlv_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [sstlv_pkg::PDATA_W-1:0]     pwdata,
    output logic      [sstlv_pkg::PDATA_W-1:0]     prdata,
    output logic                                   pready,
    output logic      [sstlv_pkg::VERSION_W-1:0]   o_max_version
);

    logic [sstlv_pkg::VERSION_W-1:0] r_max_version;
    logic                            w_sel_max;

    assign w_sel_max = (paddr[2] == sstlv_pkg::REG_MAX_VERSION);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_version <= sstlv_pkg::MAX_VERSION_RESET;
        end else if (psel && penable && pwrite && w_sel_max) begin
            r_max_version <= pwdata;
        end
    end

    assign prdata        = w_sel_max ? r_max_version : '0;
    assign pready        = 1'b1;
    assign o_max_version = r_max_version;

endmodule

`default_nettype wire

// File: src/sstlv_parse_core.sv
// Parse state and per-byte next-state logic of the send-stream TLV parser.
// Depends on sstlv_pkg; driven by send_stream_tlv_parser one beat at a time.
`default_nettype none

module sstlv_parse_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_step,
    input  wire sstlv_pkg::t_item                i_item,
    input  wire logic [sstlv_pkg::VERSION_W-1:0] i_max_version,
    output sstlv_pkg::t_result                   o_result
);

    typedef enum logic [2:0] {
        PH_STREAM,
        PH_CMD,
        PH_ATTR,
        PH_PAY,
        PH_DISCARD
    } t_phase;

    t_phase                         r_phase, n_phase;
    logic [sstlv_pkg::CNT_W-1:0]    r_hbc, n_hbc;
    logic [31:0]                    r_cbl, n_cbl;
    logic [15:0]                    r_abl, n_abl;
    logic [15:0]                    r_cmd, n_cmd;
    logic [15:0]                    r_attr, n_attr;
    logic [63:0]                    r_acc, n_acc;
    logic [15:0]                    r_pos, n_pos;
    logic [2:0]                     r_err, n_err;

    logic [7:0]                     v_b;
    logic [1:0]                     v_ver_sh;
    logic [63:0]                    v_acc;
    logic [31:0]                    v_cbl;
    logic [15:0]                    v_abl;
    logic [15:0]                    v_cmd;
    logic [15:0]                    v_attr;
    logic [15:0]                    v_need;
    sstlv_pkg::t_attr_class         v_cls;
    sstlv_pkg::t_result             v_res;

    always_comb begin
        n_phase = r_phase;
        n_hbc   = r_hbc;
        n_cbl   = r_cbl;
        n_abl   = r_abl;
        n_cmd   = r_cmd;
        n_attr  = r_attr;
        n_acc   = r_acc;
        n_pos   = r_pos;
        n_err   = r_err;

        v_b      = i_item.data_byte;
        v_ver_sh = r_hbc[1:0] + 2'd3;
        v_acc    = r_acc;
        v_cbl    = r_cbl;
        v_abl    = r_abl;
        v_cmd    = r_cmd;
        v_attr   = r_attr;
        v_need   = '0;
        v_cls    = sstlv_pkg::attr_class(r_attr);

        v_res                = '0;
        v_res.byte_role      = sstlv_pkg::ROLE_DISCARD;
        v_res.byte_echo      = v_b;

        unique case (r_phase)
            PH_STREAM: begin
                v_res.byte_role = sstlv_pkg::ROLE_STREAM;
                if (r_hbc < sstlv_pkg::MAGIC_LEN) begin
                    if (v_b != sstlv_pkg::magic_byte(r_hbc[3:0])) begin
                        n_err   = sstlv_pkg::ST_BAD_MAGIC;
                        n_phase = PH_DISCARD;
                    end else begin
                        n_hbc = r_hbc + 5'd1;
                    end
                end else begin
                    v_acc = ((r_hbc == sstlv_pkg::MAGIC_LEN) ? 64'd0 : r_acc)
                          | ({56'd0, v_b} << {v_ver_sh, 3'b000});
                    n_acc = v_acc;
                    if (r_hbc >= sstlv_pkg::VERSION_LAST) begin
                        if (v_acc > {32'd0, i_max_version}) begin
                            n_err   = sstlv_pkg::ST_VERSION;
                            n_phase = PH_DISCARD;
                        end else begin
                            n_phase = PH_CMD;
                            n_hbc   = '0;
                        end
                    end else begin
                        n_hbc = r_hbc + 5'd1;
                    end
                end
            end
            PH_CMD: begin
                v_res.byte_role = sstlv_pkg::ROLE_CMD;
                v_cbl = (r_hbc == '0) ? 32'd0 : r_cbl;
                v_cmd = (r_hbc == '0) ? 16'd0 : r_cmd;
                if (r_hbc < sstlv_pkg::CMD_LEN_END) begin
                    v_cbl = v_cbl | ({24'd0, v_b} << {r_hbc[1:0], 3'b000});
                end else if (r_hbc < sstlv_pkg::CMD_CODE_END) begin
                    v_cmd = v_cmd | ({8'd0, v_b} << {r_hbc[0], 3'b000});
                end
                n_cbl              = v_cbl;
                n_cmd              = v_cmd;
                v_res.command_code = v_cmd;
                if (r_hbc >= sstlv_pkg::CMD_HDR_LAST) begin
                    n_hbc   = '0;
                    n_phase = (v_cbl == 32'd0) ? PH_CMD : PH_ATTR;
                end else begin
                    n_hbc = r_hbc + 5'd1;
                end
            end
            PH_ATTR: begin
                v_res.byte_role    = sstlv_pkg::ROLE_ATTR;
                v_res.command_code = r_cmd;
                if (r_hbc == '0 && r_cbl < sstlv_pkg::ATTR_HDR_LEN) begin
                    n_err   = sstlv_pkg::ST_OVERFLOW;
                    n_phase = PH_DISCARD;
                end else begin
                    v_attr = (r_hbc == '0) ? 16'd0 : r_attr;
                    v_abl  = (r_hbc == '0) ? 16'd0 : r_abl;
                    if (r_hbc < sstlv_pkg::ATTR_TYPE_END) begin
                        v_attr = v_attr | ({8'd0, v_b} << {r_hbc[0], 3'b000});
                    end else begin
                        v_abl = v_abl | ({8'd0, v_b} << {r_hbc[0], 3'b000});
                    end
                    v_cbl                = r_cbl - 32'd1;
                    n_attr               = v_attr;
                    n_abl                = v_abl;
                    n_cbl                = v_cbl;
                    v_res.attribute_type = v_attr;
                    if (r_hbc >= sstlv_pkg::ATTR_HDR_LAST) begin
                        v_cls = sstlv_pkg::attr_class(v_attr);
                        unique case (v_cls)
                            sstlv_pkg::AC_U64:  v_need = sstlv_pkg::LEN_U64;
                            sstlv_pkg::AC_U32:  v_need = sstlv_pkg::LEN_U32;
                            sstlv_pkg::AC_TIME: v_need = sstlv_pkg::LEN_TIME;
                            default:            v_need = 16'd0;
                        endcase
                        n_hbc = '0;
                        priority if ({16'd0, v_abl} > v_cbl) begin
                            n_err   = sstlv_pkg::ST_OVERFLOW;
                            n_phase = PH_DISCARD;
                        end else if (v_need != 16'd0 && v_abl != v_need) begin
                            n_err   = sstlv_pkg::ST_BAD_LEN;
                            n_phase = PH_DISCARD;
                        end else if (v_abl == 16'd0) begin
                            n_phase = (v_cbl == 32'd0) ? PH_CMD : PH_ATTR;
                        end else begin
                            n_phase = PH_PAY;
                            n_pos   = '0;
                            n_acc   = '0;
                        end
                    end else begin
                        n_hbc = r_hbc + 5'd1;
                    end
                end
            end
            PH_PAY: begin
                v_res.byte_role      = sstlv_pkg::ROLE_PAYLOAD;
                v_res.command_code   = r_cmd;
                v_res.attribute_type = r_attr;
                v_res.payload_offset = r_pos;
                v_acc = ((v_cls == sstlv_pkg::AC_TIME && r_pos == sstlv_pkg::OFF_TIME_NSEC)
                        ? 64'd0 : r_acc)
                      | ({56'd0, v_b} << {r_pos[2:0], 3'b000});
                n_acc = v_acc;
                if ((v_cls == sstlv_pkg::AC_U64 && r_pos == sstlv_pkg::OFF_U64_LAST)
                    || (v_cls == sstlv_pkg::AC_U32 && r_pos == sstlv_pkg::OFF_U32_LAST)
                    || (v_cls == sstlv_pkg::AC_TIME
                        && (r_pos == sstlv_pkg::OFF_TIME_SEC
                            || r_pos == sstlv_pkg::OFF_TIME_LAST))) begin
                    v_res.value_valid = 1'b1;
                    v_res.field_value = v_acc;
                end
                n_pos = r_pos + 16'd1;
                v_abl = (r_abl != 16'd0) ? r_abl - 16'd1 : r_abl;
                v_cbl = (r_cbl != 32'd0) ? r_cbl - 32'd1 : r_cbl;
                n_abl = v_abl;
                n_cbl = v_cbl;
                if (v_abl == 16'd0) begin
                    n_hbc   = '0;
                    n_phase = (v_cbl == 32'd0) ? PH_CMD : PH_ATTR;
                end
            end
            PH_DISCARD: begin
                v_res.byte_role = sstlv_pkg::ROLE_DISCARD;
            end
            default: begin
                v_res.byte_role = sstlv_pkg::ROLE_DISCARD;
            end
        endcase

        if (i_item.end_of_stream && n_err == sstlv_pkg::ST_OK
            && !(n_phase == PH_CMD && n_hbc == '0)) begin
            n_err = sstlv_pkg::ST_TRUNC;
        end
        v_res.status = n_err;

        if (i_item.end_of_stream) begin
            n_phase = PH_STREAM;
            n_hbc   = '0;
            n_cbl   = '0;
            n_abl   = '0;
            n_cmd   = '0;
            n_attr  = '0;
            n_acc   = '0;
            n_pos   = '0;
            n_err   = sstlv_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STREAM;
            r_hbc   <= '0;
            r_cbl   <= '0;
            r_abl   <= '0;
            r_cmd   <= '0;
            r_attr  <= '0;
            r_acc   <= '0;
            r_pos   <= '0;
            r_err   <= sstlv_pkg::ST_OK;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_hbc   <= n_hbc;
            r_cbl   <= n_cbl;
            r_abl   <= n_abl;
            r_cmd   <= n_cmd;
            r_attr  <= n_attr;
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_err   <= n_err;
        end
    end

    assign o_result = v_res;

endmodule

`default_nettype wire

// File: src/sstlv_chk.sv
// Port-level checker for send_stream_tlv_parser, bound to the top level.
// Depends on sstlv_pkg.
`default_nettype none

module sstlv_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [sstlv_pkg::TDATA_W-1:0] m_axis_tdata,
    input wire logic [sstlv_pkg::TUSER_W-1:0] m_axis_tuser
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    a_value_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == sstlv_pkg::ROLE_PAYLOAD)
        else $error("value outside attribute payload");

    a_discard_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] == sstlv_pkg::ROLE_DISCARD
            |-> m_axis_tdata[122:120] != sstlv_pkg::ST_OK)
        else $error("discarded beat without latched error");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] != sstlv_pkg::ROLE_PAYLOAD
            |-> m_axis_tdata[47:32] == 16'd0)
        else $error("payload offset outside payload");

endmodule

bind send_stream_tlv_parser sstlv_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
